/* rtl/sppwm_pkg.sv */
package sppwm_pkg;

  // Fixed field widths of the item and register interfaces.
  localparam int unsigned CH_IDX_W   = 4;
  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned LEVELS_W   = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  // Parameter defaults.
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned PERIOD_BITS_DEF = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 4'd3;

  // Register reset values and limits.
  localparam logic [7:0]          PRESCALE_RST = 8'd30;
  localparam logic [7:0]          PRESCALE_MIN = 8'd3;
  localparam logic [CH_IDX_W-1:0] FIRST_CH_RST = 4'd0;
  localparam logic [CH_IDX_W-1:0] LAST_CH_RST  = 4'd15;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/sppwm_div.sv */
module sppwm_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    numer,
  input  logic [DEN_W-1:0]    denom,
  output sppwm_pkg::div_sts_t sts,
  output logic [NUM_W-1:0]    quotient
);
  import sppwm_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next numerator bit and try a subtract.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = numer;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= denom;
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/staggered_phase_pwm_generator_unit.sv */
// Channel  Ports                                              Handshake
// in       in_opcode, in_channel_index, in_duty_value         in_valid / in_stall
// out      out_channel_levels, out_pwm_count                  out_valid / out_stall
// cfg      cfg_index, cfg_data                                cfg_valid / cfg_ready
//
// A tick, an ignored write, an inactive channel or a full-on write goes straight to emit.
// A duty write to an active channel first waits in the divide state for the
// bit-serial divider that computes the phase start.
// Reset (rst_n low, synchronous) sets every channel full off and clears the counters.
// A stalled result waits in the output register while the next beat is taken.
// cfg_ready is always high; users must write registers only while idle; not enforced.
module staggered_phase_pwm_generator_unit #(
  parameter int unsigned CHANNELS    = sppwm_pkg::CHANNELS_DEF,
  parameter int unsigned PERIOD_BITS = sppwm_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [sppwm_pkg::CH_IDX_W-1:0]   in_channel_index,
  input  logic [sppwm_pkg::DUTY_W-1:0]     in_duty_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sppwm_pkg::LEVELS_W-1:0]   out_channel_levels,
  output logic [PERIOD_BITS-1:0]           out_pwm_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sppwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sppwm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sppwm_pkg::*;

  localparam int unsigned PB       = PERIOD_BITS;
  localparam int unsigned PH_W     = PB + 1;
  localparam int unsigned CMP_W    = (PH_W > DUTY_W) ? PH_W : DUTY_W;
  localparam int unsigned NUM_W    = CH_IDX_W + PB;
  localparam int unsigned DEN_W    = CH_IDX_W + 1;
  localparam int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FULL_CNT = 1 << PB;

  localparam logic [PH_W-1:0] PH_FULL = PH_W'(FULL_CNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [7:0]          prescale_r;
  logic [CH_IDX_W-1:0] first_r, last_r;
  logic                invert_r;
  logic [PH_W-1:0]     start_r [CHANNELS];
  logic [PH_W-1:0]     stop_r  [CHANNELS];
  logic [7:0]          tdiv_r;
  logic [PB-1:0]       pcnt_r;
  logic [CH_IDX_W-1:0] ch_r;
  logic [DUTY_W-1:0]   duty_r;

  logic                out_valid_r;
  logic [LEVELS_W-1:0] out_levels_r;
  logic [PB-1:0]       out_count_r;

  logic                in_acc;
  logic                ch_exists;
  logic                ch_active;
  logic                duty_full;
  logic                range_ok;
  logic                div_start;
  logic [NUM_W-1:0]    div_numer;
  logic [DEN_W-1:0]    div_denom;
  logic [NUM_W-1:0]    div_quo;
  div_sts_t            div_sts;
  logic [CMP_W:0]      stop_sum;
  logic [LEVELS_W-1:0] levels;
  logic                out_free;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Decode of the incoming write beat.
  assign range_ok  = (first_r <= last_r);
  assign ch_exists = ({1'b0, in_channel_index} < (CH_IDX_W + 1)'(CHANNELS));
  assign ch_active = ch_exists && range_ok && (in_channel_index >= first_r) &&
                     (in_channel_index <= last_r);
  assign duty_full = (CMP_W'(in_duty_value) >= CMP_W'(FULL_CNT));
  assign div_start = in_acc && (in_opcode == OP_WRITE) && ch_active && !duty_full;

  // Phase start = (channel - first) * 2^PERIOD_BITS / (last - first + 1).
  assign div_numer = {in_channel_index - first_r, PB'(0)};
  assign div_denom = {1'b0, last_r} - {1'b0, first_r} + DEN_W'(1);

  sppwm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // Stop count wraps inside the period.
  assign stop_sum = (CMP_W + 1)'(div_quo[PB-1:0]) + (CMP_W + 1)'(duty_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = div_start ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      first_r    <= FIRST_CH_RST;
      last_r     <= LAST_CH_RST;
      invert_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESCALE: prescale_r <= (cfg_data < PRESCALE_MIN) ? PRESCALE_MIN : cfg_data;
        CFG_FIRST_CH: first_r    <= cfg_data[CH_IDX_W-1:0];
        CFG_LAST_CH:  last_r     <= cfg_data[CH_IDX_W-1:0];
        CFG_INVERT:   invert_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Prescaler and period counter advance on tick beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdiv_r <= '0;
      pcnt_r <= '0;
    end else if (in_acc && (in_opcode == OP_TICK)) begin
      if (tdiv_r >= prescale_r) begin
        tdiv_r <= '0;
        pcnt_r <= pcnt_r + 1'b1;
      end else begin
        tdiv_r <= tdiv_r + 1'b1;
      end
    end
  end

  // Pending write held while the divider runs.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_channel_index;
      duty_r <= in_duty_value;
    end
  end

  // Channel phase registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= '0;
        stop_r[i]  <= PH_FULL;
      end
    end else if (in_acc && (in_opcode == OP_WRITE) && ch_exists && !div_start) begin
      if (!ch_active) begin
        start_r[in_channel_index[IDX_W-1:0]] <= '0;
        stop_r[in_channel_index[IDX_W-1:0]]  <= PH_FULL;
      end else begin
        start_r[in_channel_index[IDX_W-1:0]] <= PH_FULL;
        stop_r[in_channel_index[IDX_W-1:0]]  <= '0;
      end
    end else if ((state_r == ST_DIV) && div_sts.done) begin
      start_r[ch_r[IDX_W-1:0]] <= {1'b0, div_quo[PB-1:0]};
      if (duty_r == '0) begin
        stop_r[ch_r[IDX_W-1:0]] <= PH_FULL;
      end else begin
        stop_r[ch_r[IDX_W-1:0]] <= {1'b0, stop_sum[PB-1:0]};
      end
    end
  end

  // Output level of each channel from its start, stop and the counter.
  always_comb begin
    levels = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      logic act;
      logic lv;
      act = range_ok && (CH_IDX_W'(i) >= first_r) && (CH_IDX_W'(i) <= last_r);
      if (!act || stop_r[i][PB]) begin
        lv = 1'b0;
      end else if (start_r[i][PB]) begin
        lv = 1'b1;
      end else if (start_r[i][PB-1:0] < stop_r[i][PB-1:0]) begin
        lv = (pcnt_r >= start_r[i][PB-1:0]) && (pcnt_r < stop_r[i][PB-1:0]);
      end else if (start_r[i][PB-1:0] > stop_r[i][PB-1:0]) begin
        lv = (pcnt_r >= start_r[i][PB-1:0]) || (pcnt_r < stop_r[i][PB-1:0]);
      end else begin
        lv = 1'b0;
      end
      levels[i] = lv ^ invert_r;
    end
  end

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_levels_r <= levels;
      out_count_r  <= pcnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_levels = out_levels_r;
  assign out_pwm_count      = out_count_r;

`ifndef SYNTH
  // The divider runs and reports completion only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_sts.busy || div_sts.done) |-> (state_r == ST_DIV))
    else $error("divider active outside of the divide state");

  // An accepted beat always moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after an accepted beat");

  // The period counter moves only after an accepted tick beat.
  a_count_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_opcode == OP_TICK)) |=> $stable(pcnt_r))
    else $error("period counter changed without a tick");
`endif

endmodule

/* sim/tb_staggered_phase_pwm_generator_unit.sv */
module tb_staggered_phase_pwm_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sppwm_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned BLOCK_BEATS   = 90;
  localparam int unsigned WRAP_BEATS    = 100;
  localparam logic [12:0] PERIOD_FULL   = 13'h1000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

  typedef struct packed {
    logic [LEVELS_W-1:0] levels;
    logic [11:0]         count;
  } pwm_out_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                op;
    logic [CH_IDX_W-1:0] ch;
    logic [DUTY_W-1:0]   duty;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    logic                fixed;
    logic [LEVELS_W-1:0] levels;
    logic [11:0]         count;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  logic [CH_IDX_W-1:0]   in_channel_index;
  logic [DUTY_W-1:0]     in_duty_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVELS_W-1:0]   out_channel_levels;
  logic [11:0]           out_pwm_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Fixed expectation carried alongside the beat on the input channel.
  logic                  beat_fixed;
  logic [LEVELS_W-1:0]   beat_levels;
  logic [11:0]           beat_count;

  staggered_phase_pwm_generator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_channel_index   (in_channel_index),
    .in_duty_value      (in_duty_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_levels (out_channel_levels),
    .out_pwm_count      (out_pwm_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Mirror of the generator state and its registers.
  logic [12:0]         start_m [16];
  logic [12:0]         stop_m  [16];
  logic [7:0]          div_m;
  logic [11:0]         count_m;
  logic [7:0]          prescale_m;
  logic [CH_IDX_W-1:0] first_m;
  logic [CH_IDX_W-1:0] last_m;
  logic                invert_m;

  pwm_out_t  due_outputs[$];
  stim_row_t directed_rows[$];

  int send_gap_pct = 38;
  int stall_pct    = 67;
  int n_errors     = 0;
  int n_ticks      = 0;
  int n_writes     = 0;
  int n_results    = 0;
  int n_regs       = 0;
  int n_wraps      = 0;
  int idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit channel_enabled(int unsigned ch);
    return first_m <= last_m && ch >= first_m && ch <= last_m;
  endfunction

  // A full stop bit forces off, a full start bit forces on, otherwise the
  // window runs from start up to stop, wrapping when stop is below start.
  function automatic bit channel_on(int unsigned ch);
    logic [11:0] s;
    logic [11:0] e;
    s = start_m[ch][11:0];
    e = stop_m[ch][11:0];
    if (!channel_enabled(ch)) return 1'b0;
    if (stop_m[ch][12]) return 1'b0;
    if (start_m[ch][12]) return 1'b1;
    if (s < e) return count_m >= s && count_m < e;
    if (s > e) return count_m >= s || count_m < e;
    return 1'b0;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PRESCALE: prescale_m = (val < PRESCALE_MIN) ? PRESCALE_MIN : val;
      CFG_FIRST_CH: first_m = val[CH_IDX_W-1:0];
      CFG_LAST_CH:  last_m = val[CH_IDX_W-1:0];
      CFG_INVERT:   invert_m = val[0];
      default: ;
    endcase
  endfunction

  // Advances the mirrored state by one beat and returns the levels and count.
  function automatic pwm_out_t predict_item(logic op, logic [CH_IDX_W-1:0] ch,
                                            logic [DUTY_W-1:0] duty);
    pwm_out_t    r;
    int unsigned span;
    int unsigned base;
    if (op == OP_TICK) begin
      if (div_m >= prescale_m) begin
        div_m = '0;
        count_m = count_m + 12'd1;
        if (count_m == '0) n_wraps++;
      end else begin
        div_m = div_m + 8'd1;
      end
    end else if (!channel_enabled(ch)) begin
      start_m[ch] = '0;
      stop_m[ch] = PERIOD_FULL;
    end else begin
      span = int'(last_m) - int'(first_m) + 1;
      base = ((int'(ch) - int'(first_m)) * 4096) / span;
      if (duty == '0) begin
        start_m[ch] = 13'(base);
        stop_m[ch] = PERIOD_FULL;
      end else if (duty >= PERIOD_FULL) begin
        start_m[ch] = PERIOD_FULL;
        stop_m[ch] = '0;
      end else begin
        start_m[ch] = 13'(base);
        stop_m[ch] = {1'b0, 12'(base + int'(duty))};
      end
    end
    for (int i = 0; i < 16; i++) r.levels[i] = channel_on(i) ^ invert_m;
    r.count = count_m;
    return r;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Output checking, input prediction and register tracking, all at the rising edge.
  always @(posedge clk) begin : track_beats
    pwm_out_t got;
    pwm_out_t want;
    pwm_out_t next;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.levels = out_channel_levels;
        got.count = out_pwm_count;
        n_results++;
        if (due_outputs.size() == 0) begin
          n_errors++;
          $display("%0t ns: result with none due, actual levels %04h count %03h",
                   $time, got.levels, got.count);
        end else begin
          want = due_outputs.pop_front();
          report_field("channel_levels", want.levels, got.levels);
          report_field("pwm_count", want.count, got.count);
        end
      end
      if (in_valid && !in_stall) begin
        next = predict_item(in_opcode, in_channel_index, in_duty_value);
        if (in_opcode == OP_TICK) n_ticks++;
        else n_writes++;
        if (beat_fixed) begin
          next.levels = beat_levels;
          next.count = beat_count;
        end
        due_outputs.push_back(next);
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_index, cfg_data);
        n_regs++;
      end
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
        $display("staggered_phase_pwm_generator_unit regression: fail");
        $finish;
      end
    end
  end

  // Result backpressure.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input logic op, input logic [CH_IDX_W-1:0] ch,
                           input logic [DUTY_W-1:0] duty, input logic fixed = 1'b0,
                           input logic [LEVELS_W-1:0] levels = '0,
                           input logic [11:0] count = '0);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_channel_index <= ch;
    in_duty_value <= duty;
    beat_fixed <= fixed;
    beat_levels <= levels;
    beat_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender back until every due result has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_item(input logic op, input logic [CH_IDX_W-1:0] ch,
                          input logic [DUTY_W-1:0] duty, input logic fixed = 1'b0,
                          input logic [LEVELS_W-1:0] levels = '0,
                          input logic [11:0] count = '0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.op = op;
    r.ch = ch;
    r.duty = duty;
    r.fixed = fixed;
    r.levels = levels;
    r.count = count;
    directed_rows.push_back(r);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    directed_rows.push_back(r);
  endtask

  // Random register settings, weighted toward short prescales and ordered
  // channel ranges, with the extremes and reversed ranges mixed in.
  task automatic pick_settings();
    logic [7:0]          ps;
    logic [CH_IDX_W-1:0] lo;
    logic [CH_IDX_W-1:0] hi;
    logic [CH_IDX_W-1:0] a;
    logic [CH_IDX_W-1:0] b;
    case ($urandom_range(7))
      0: ps = 8'($urandom_range(2, 0));
      1: ps = 8'd255;
      2: ps = 8'($urandom_range(255, 0));
      default: ps = 8'($urandom_range(8, 3));
    endcase
    a = 4'($urandom);
    b = 4'($urandom);
    case ($urandom_range(9))
      0: begin lo = 4'd15; hi = 4'd0; end
      1: begin lo = 4'd0; hi = 4'd15; end
      2: begin lo = a; hi = a; end
      3: begin lo = 4'd0; hi = 4'd0; end
      4: begin lo = 4'd15; hi = 4'd15; end
      5: begin lo = a; hi = b; end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    write_reg(CFG_PRESCALE, ps);
    write_reg(CFG_FIRST_CH, {4'($urandom), lo});
    write_reg(CFG_LAST_CH, {4'($urandom), hi});
    write_reg(CFG_INVERT, 8'($urandom));
    if ($urandom_range(3) == 0)
      write_reg(4'($urandom_range(15, int'(CFG_INVERT) + 1)), 8'($urandom));
  endtask

  task automatic send_random_item(input int tick_pct);
    logic [DUTY_W-1:0] duty;
    if ($urandom_range(99) < tick_pct) begin
      send_item(OP_TICK, 4'($urandom), 13'($urandom));
    end else begin
      case ($urandom_range(9))
        0: duty = '0;
        1: duty = PERIOD_FULL;
        2: duty = 13'($urandom_range(8191, 4097));
        default: duty = 13'($urandom_range(4095, 1));
      endcase
      send_item(OP_WRITE, 4'($urandom), duty);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_opcode = OP_TICK;
    in_channel_index = '0;
    in_duty_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    beat_fixed = 1'b0;
    beat_levels = '0;
    beat_count = '0;
    rst_n = 1'b0;

    // Mirror starts from the reset state: every channel full off.
    for (int i = 0; i < 16; i++) begin
      start_m[i] = '0;
      stop_m[i] = PERIOD_FULL;
    end
    div_m = '0;
    count_m = '0;
    prescale_m = PRESCALE_RST;
    first_m = FIRST_CH_RST;
    last_m = LAST_CH_RST;
    invert_m = 1'b0;

    // Directed table. Fixed results only right after reset and for full on/off.
    add_item(OP_TICK, 4'd0, '0, 1'b1, 16'h0000, 12'd0);
    add_item(OP_WRITE, 4'd0, 13'd0, 1'b1, 16'h0000, 12'd0);
    add_item(OP_WRITE, 4'd0, 13'd4096, 1'b1, 16'h0001, 12'd0);
    add_item(OP_WRITE, 4'd15, 13'd8191, 1'b1, 16'h8001, 12'd0);
    add_item(OP_WRITE, 4'd1, 13'd4095);
    add_item(OP_WRITE, 4'd2, 13'd1);
    add_item(OP_WRITE, 4'd3, 13'd2048);
    add_item(OP_WRITE, 4'd8, 13'd4095);
    add_reg(CFG_INVERT, 8'h01);
    add_item(OP_TICK, 4'd15, 13'h1FFF);
    // Unused data bits are dropped and a prescale below three reads as three.
    add_reg(CFG_INVERT, 8'hFE);
    add_reg(CFG_PRESCALE, 8'h00);
    for (int i = 0; i < 4; i++) add_item(OP_TICK, 4'd0, '0);
    // Let the divider run past a prescale that is then lowered.
    add_reg(CFG_PRESCALE, 8'hFF);
    for (int i = 0; i < 6; i++) add_item(OP_TICK, 4'd0, '0);
    add_reg(CFG_PRESCALE, 8'h02);
    add_item(OP_TICK, 4'd0, '0);
    // Spare register index, then a reversed range that disables every channel.
    add_reg(CFG_SPARE, 8'hFF);
    add_reg(CFG_FIRST_CH, 8'hF4);
    add_reg(CFG_LAST_CH, 8'h03);
    add_item(OP_WRITE, 4'd4, 13'd100);
    add_reg(CFG_FIRST_CH, 8'h05);
    add_reg(CFG_LAST_CH, 8'h05);
    add_item(OP_WRITE, 4'd5, 13'd2048);
    add_item(OP_WRITE, 4'd6, 13'd4096);
    add_reg(CFG_FIRST_CH, 8'hF0);
    add_reg(CFG_LAST_CH, 8'h0F);
    add_item(OP_WRITE, 4'd15, 13'd1);
    add_item(OP_TICK, 4'd0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].duty,
                  directed_rows[i].fixed, directed_rows[i].levels, directed_rows[i].count);
      end
    end

    // Random blocks under three idling patterns, new settings per block.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 38; stall_pct = 67; end
        1: begin send_gap_pct = 67; stall_pct = 38; end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        drain_results();
        pick_settings();
        for (int n = 0; n < BLOCK_BEATS; n++) send_random_item(70);
      end
    end

    // Tick-heavy run at the shortest prescale over the full channel range.
    drain_results();
    write_reg(CFG_PRESCALE, 8'h01);
    write_reg(CFG_FIRST_CH, 8'h00);
    write_reg(CFG_LAST_CH, 8'h0F);
    write_reg(CFG_INVERT, 8'($urandom));
    for (int n = 0; n < WRAP_BEATS; n++) send_random_item(98);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d ticks and %0d duty writes over %0d register writes,",
             n_ticks, n_writes, n_regs);
    $display("%0d results checked, %0d counter wraps, %0d mismatches.",
             n_results, n_wraps, n_errors);
    if (n_errors == 0 && due_outputs.size() == 0) begin
      $display("staggered_phase_pwm_generator_unit regression: pass");
    end else begin
      $display("staggered_phase_pwm_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
